// ===== rtl/core/polynomial_coordinate_warp_assert.svh =====
// Assertion macros for the warp block and its checker
`ifndef POLYNOMIAL_COORDINATE_WARP_ASSERT_SVH
`define POLYNOMIAL_COORDINATE_WARP_ASSERT_SVH

// clocked check, off while in reset
`define PCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also holds through reset
`define PCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pcw_pkg.sv =====
`timescale 1ns / 1ps
package pcw_pkg;
  localparam int COEFF_WIDTH_DEF = 48;
  localparam int NUM_TERMS_DEF   = 16;
  localparam int MUL_LAT         = 4;
  localparam int NORM_FRAC       = 32;
  localparam int LIM_LOG         = 58;
  localparam int VAL_W           = LIM_LOG + 2;
  localparam int SUM_W           = 64;
  localparam int OUT_LIM_LOG     = 31;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 33;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y   = 3'd4;

  localparam logic [1:0] MODE_BILINEAR  = 2'd0;
  localparam logic [1:0] MODE_BISQUARED = 2'd1;
  localparam logic [1:0] MODE_BICUBIC   = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [4:0] COEF_X_LIN = 5'd1;
  localparam logic [4:0] COEF_Y_LIN = 5'd18;

  localparam logic [32:0] INV_ONE = 33'h1_0000_0000;
  localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(64'd1 << NORM_FRAC);

  // monomial order: 1 X Y XY X2 Y2 X2Y XY2 X2Y2 X3 Y3 X3Y XY3 X3Y2 X2Y3 X3Y3
  localparam logic [1:0] POW_X [16] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1,
                                       2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3};
  localparam logic [1:0] POW_Y [16] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2,
                                       2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3, 2'd3};
endpackage

// ===== rtl/core/pcw_if.sv =====
`timescale 1ns / 1ps
interface pcw_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [4:0]         coeff_index;
  logic signed [47:0] coeff_value;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;

  modport source (output valid, op, coeff_index, coeff_value, x_in, y_in, input ready);
  modport sink   (input valid, op, coeff_index, coeff_value, x_in, y_in, output ready);
endinterface

interface pcw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;

  modport source (output valid, x_out, y_out, input ready);
  modport sink   (input valid, x_out, y_out, output ready);
endinterface

// ===== rtl/core/pcw_mul.sv =====
`timescale 1ns / 1ps
// round(a*b / 2^SH), ties away from zero, saturated to +-2^LIMW; four stages
module pcw_mul #(
  parameter int AW   = 32,
  parameter int BW   = 32,
  parameter int SH   = 16,
  parameter int LIMW = 58
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic signed [LIMW+1:0] p
);
  localparam logic [127:0] RND = 128'd1 << (SH - 1);
  localparam logic [127:0] LIM = 128'd1 << LIMW;

  logic signed [64:0]    sa, sb;
  logic [63:0]           ma_r, mb_r, ma_nxt, mb_nxt;
  logic                  neg_r, neg2_r, neg3_r;
  logic [63:0]           p00_r, p01_r, p10_r, p11_r;
  logic [127:0]          prod_r, prod_nxt, shf;
  logic [LIMW:0]         mag;
  logic signed [LIMW+1:0] p_r, p_nxt;

  always_comb begin
    sa       = 65'(a);
    sb       = 65'(b);
    ma_nxt   = sa[64] ? 64'(-sa) : 64'(sa);
    mb_nxt   = sb[64] ? 64'(-sb) : 64'(sb);
    prod_nxt = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
             + {p11_r, 64'd0} + RND;
    shf      = prod_r >> SH;
    mag      = (shf > LIM) ? LIM[LIMW:0] : shf[LIMW:0];
    p_nxt    = neg3_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      neg_r  <= a[AW-1] ^ b[BW-1];
      p00_r  <= ma_r[31:0] * mb_r[31:0];
      p01_r  <= ma_r[31:0] * mb_r[63:32];
      p10_r  <= ma_r[63:32] * mb_r[31:0];
      p11_r  <= ma_r[63:32] * mb_r[63:32];
      neg2_r <= neg_r;
      prod_r <= prod_nxt;
      neg3_r <= neg2_r;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;
endmodule

// ===== rtl/core/polynomial_coordinate_warp.sv =====
`timescale 1ns / 1ps
// Polynomial coordinate warp.
// in_word takes words of two kinds: a load word (op 0) writes one coefficient
// and gives no result; a point word (op 1) gives one out_word with the warped
// x and y in signed Q16.16, saturated. Both use valid/ready handshakes.
// cfg_we/cfg_index/cfg_data write mode, widths and reciprocals; write them
// only while no word is in flight.
// Throughput: one word per cycle while out_word is not stalled. The path from
// input accept to out_word valid has 27 register stages, the first loaded at the
// accept edge: six chained four-stage multipliers (normalise, square, cube,
// monomial, coefficient, denormalise) plus two adder stages and the output
// register. A load affects every point accepted after it.
// Reset: empty pipeline, identity coefficients, bilinear mode, widths one,
// reciprocals one.
// Stall: while out_word holds a word that is not taken, the whole pipeline
// freezes and in_word.ready is low; nothing is lost or repeated.
module polynomial_coordinate_warp #(
  parameter int COEFF_WIDTH = pcw_pkg::COEFF_WIDTH_DEF,
  parameter int NUM_TERMS   = pcw_pkg::NUM_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  pcw_in_if.sink                          in_word,
  pcw_out_if.source                       out_word
);
  import pcw_pkg::*;

  localparam int L        = MUL_LAT;
  localparam int PIPE     = 6 * L + 2;
  localparam int COEF_STG = 4 * L;
  localparam int CF       = COEFF_WIDTH - 8;
  localparam logic signed [COEFF_WIDTH-1:0] C_ONE = COEFF_WIDTH'(64'd1 << CF);
  localparam logic signed [OUT_LIM_LOG+1:0] OUT_MAX = 33'sh0_7FFF_FFFF;

  logic [1:0]  mode_r;
  logic [15:0] xw_r, yw_r;
  logic [32:0] invx_r, invy_r;

  logic en, acc;
  logic pv_r [PIPE];
  logic ldv_r [COEF_STG];
  logic [4:0] ldi_r [COEF_STG];
  logic signed [COEFF_WIDTH-1:0] ldc_r [COEF_STG];
  logic signed [COEFF_WIDTH-1:0] cin;
  logic signed [COEFF_WIDTH-1:0] coef_r [32];

  logic signed [VAL_W-1:0] xp1, xp2, xp3, yp1, yp2, yp3;
  logic signed [VAL_W-1:0] xa_r [3*L];
  logic signed [VAL_W-1:0] xb_r [2*L];
  logic signed [VAL_W-1:0] xc_r [L];
  logic signed [VAL_W-1:0] ya_r [3*L];
  logic signed [VAL_W-1:0] yb_r [2*L];
  logic signed [VAL_W-1:0] yc_r [L];
  logic signed [VAL_W-1:0] px3 [1:3];
  logic signed [VAL_W-1:0] py3 [1:3];
  logic signed [VAL_W-1:0] px4 [1:3];
  logic signed [VAL_W-1:0] py4 [1:3];
  logic signed [VAL_W-1:0] tx [16];
  logic signed [VAL_W-1:0] ty [16];

  logic [4:0]  nterm;
  logic [15:0] use_term;
  logic signed [SUM_W-1:0] sx1_nxt [4];
  logic signed [SUM_W-1:0] sy1_nxt [4];
  logic signed [SUM_W-1:0] sx1_r [4];
  logic signed [SUM_W-1:0] sy1_r [4];
  logic signed [SUM_W-1:0] sx2_nxt, sy2_nxt, sx2_r, sy2_r;
  logic signed [OUT_LIM_LOG+1:0] rx, ry;
  logic signed [31:0] out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic out_valid_r;

  assign en  = !out_valid_r || out_word.ready;
  assign acc = in_word.valid && en;
  assign in_word.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BILINEAR;
      xw_r   <= 16'd1;
      yw_r   <= 16'd1;
      invx_r <= INV_ONE;
      invy_r <= INV_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r <= cfg_data[1:0];
        REG_X_WIDTH: xw_r   <= cfg_data[15:0];
        REG_Y_WIDTH: yw_r   <= cfg_data[15:0];
        REG_INV_X:   invx_r <= cfg_data;
        REG_INV_Y:   invy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) pv_r[i] <= 1'b0;
      for (int i = 0; i < COEF_STG; i++) ldv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r[0]  <= acc && (in_word.op == OP_POINT);
      ldv_r[0] <= acc && (in_word.op == OP_LOAD);
      for (int i = 1; i < PIPE; i++) pv_r[i] <= pv_r[i-1];
      for (int i = 1; i < COEF_STG; i++) ldv_r[i] <= ldv_r[i-1];
      out_valid_r <= pv_r[PIPE-1];
    end
  end

  if (COEFF_WIDTH >= 48) begin : g_cwide
    assign cin = COEFF_WIDTH'(in_word.coeff_value) <<< (COEFF_WIDTH - 48);
  end else begin : g_cnarrow
    assign cin = COEFF_WIDTH'(in_word.coeff_value >>> (48 - COEFF_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ldi_r[0] <= in_word.coeff_index;
      ldc_r[0] <= cin;
      for (int i = 1; i < COEF_STG; i++) begin
        ldi_r[i] <= ldi_r[i-1];
        ldc_r[i] <= ldc_r[i-1];
      end
    end
  end

  // written where the terms read it, so loads and points stay in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) coef_r[i] <= '0;
      coef_r[COEF_X_LIN] <= C_ONE;
      coef_r[COEF_Y_LIN] <= C_ONE;
    end else if (en && ldv_r[COEF_STG-1]) begin
      coef_r[ldi_r[COEF_STG-1]] <= ldc_r[COEF_STG-1];
    end
  end

  pcw_mul #(.AW(32), .BW(34), .SH(16), .LIMW(LIM_LOG)) u_nx (
    .clk(clk), .en(en), .a(in_word.x_in), .b({1'b0, invx_r}), .p(xp1));
  pcw_mul #(.AW(32), .BW(34), .SH(16), .LIMW(LIM_LOG)) u_ny (
    .clk(clk), .en(en), .a(in_word.y_in), .b({1'b0, invy_r}), .p(yp1));
  pcw_mul #(.AW(VAL_W), .BW(VAL_W), .SH(NORM_FRAC), .LIMW(LIM_LOG)) u_x2 (
    .clk(clk), .en(en), .a(xp1), .b(xp1), .p(xp2));
  pcw_mul #(.AW(VAL_W), .BW(VAL_W), .SH(NORM_FRAC), .LIMW(LIM_LOG)) u_y2 (
    .clk(clk), .en(en), .a(yp1), .b(yp1), .p(yp2));
  pcw_mul #(.AW(VAL_W), .BW(VAL_W), .SH(NORM_FRAC), .LIMW(LIM_LOG)) u_x3 (
    .clk(clk), .en(en), .a(xp2), .b(xa_r[L-1]), .p(xp3));
  pcw_mul #(.AW(VAL_W), .BW(VAL_W), .SH(NORM_FRAC), .LIMW(LIM_LOG)) u_y3 (
    .clk(clk), .en(en), .a(yp2), .b(ya_r[L-1]), .p(yp3));

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r[0] <= xp1;
      ya_r[0] <= yp1;
      xb_r[0] <= xp2;
      yb_r[0] <= yp2;
      xc_r[0] <= xp3;
      yc_r[0] <= yp3;
      for (int i = 1; i < 3 * L; i++) begin
        xa_r[i] <= xa_r[i-1];
        ya_r[i] <= ya_r[i-1];
      end
      for (int i = 1; i < 2 * L; i++) begin
        xb_r[i] <= xb_r[i-1];
        yb_r[i] <= yb_r[i-1];
      end
      for (int i = 1; i < L; i++) begin
        xc_r[i] <= xc_r[i-1];
        yc_r[i] <= yc_r[i-1];
      end
    end
  end

  assign px3[1] = xa_r[2*L-1];
  assign px3[2] = xb_r[L-1];
  assign px3[3] = xp3;
  assign py3[1] = ya_r[2*L-1];
  assign py3[2] = yb_r[L-1];
  assign py3[3] = yp3;
  assign px4[1] = xa_r[3*L-1];
  assign px4[2] = xb_r[2*L-1];
  assign px4[3] = xc_r[L-1];
  assign py4[1] = ya_r[3*L-1];
  assign py4[2] = yb_r[2*L-1];
  assign py4[3] = yc_r[L-1];

  for (genvar k = 0; k < 16; k++) begin : g_term
    localparam int PX = int'(POW_X[k]);
    localparam int PY = int'(POW_Y[k]);
    if (k < NUM_TERMS) begin : g_lane
      logic signed [VAL_W-1:0] mono;
      if (PX == 0 && PY == 0) begin : g_one
        assign mono = VAL_ONE;
      end else if (PX == 0) begin : g_ypow
        assign mono = py4[PY];
      end else if (PY == 0) begin : g_xpow
        assign mono = px4[PX];
      end else begin : g_cross
        pcw_mul #(.AW(VAL_W), .BW(VAL_W), .SH(NORM_FRAC), .LIMW(LIM_LOG)) u_mono (
          .clk(clk), .en(en), .a(px3[PX]), .b(py3[PY]), .p(mono));
      end
      pcw_mul #(.AW(COEFF_WIDTH), .BW(VAL_W), .SH(CF), .LIMW(LIM_LOG)) u_tx (
        .clk(clk), .en(en), .a(coef_r[k]), .b(mono), .p(tx[k]));
      pcw_mul #(.AW(COEFF_WIDTH), .BW(VAL_W), .SH(CF), .LIMW(LIM_LOG)) u_ty (
        .clk(clk), .en(en), .a(coef_r[16+k]), .b(mono), .p(ty[k]));
    end else begin : g_none
      assign tx[k] = '0;
      assign ty[k] = '0;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_BISQUARED: nterm = 5'd9;
      MODE_BICUBIC:   nterm = 5'd16;
      default:        nterm = 5'd4;
    endcase
    if (nterm > 5'(NUM_TERMS)) nterm = 5'(NUM_TERMS);
    for (int k = 0; k < 16; k++) use_term[k] = (5'(k) < nterm);
  end

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      sx1_nxt[g] = '0;
      sy1_nxt[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (use_term[4*g+j]) begin
          sx1_nxt[g] = sx1_nxt[g] + SUM_W'(tx[4*g+j]);
          sy1_nxt[g] = sy1_nxt[g] + SUM_W'(ty[4*g+j]);
        end
      end
    end
    sx2_nxt = sx1_r[0] + sx1_r[1] + sx1_r[2] + sx1_r[3];
    sy2_nxt = sy1_r[0] + sy1_r[1] + sy1_r[2] + sy1_r[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        sx1_r[g] <= sx1_nxt[g];
        sy1_r[g] <= sy1_nxt[g];
      end
      sx2_r <= sx2_nxt;
      sy2_r <= sy2_nxt;
    end
  end

  pcw_mul #(.AW(SUM_W), .BW(17), .SH(16), .LIMW(OUT_LIM_LOG)) u_dx (
    .clk(clk), .en(en), .a(sx2_r), .b({1'b0, xw_r}), .p(rx));
  pcw_mul #(.AW(SUM_W), .BW(17), .SH(16), .LIMW(OUT_LIM_LOG)) u_dy (
    .clk(clk), .en(en), .a(sy2_r), .b({1'b0, yw_r}), .p(ry));

  always_comb begin
    out_x_nxt = (rx > OUT_MAX) ? OUT_MAX[31:0] : rx[31:0];
    out_y_nxt = (ry > OUT_MAX) ? OUT_MAX[31:0] : ry[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
    end
  end

  assign out_word.valid = out_valid_r;
  assign out_word.x_out = out_x_r;
  assign out_word.y_out = out_y_r;
endmodule

// ===== rtl/core/pcw_checker.sv =====
`timescale 1ns / 1ps
`include "polynomial_coordinate_warp_assert.svh"
module pcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] x_out,
  input logic [31:0] y_out
);
  `PCW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "word dropped under stall")
  `PCW_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(x_out) && $stable(y_out), "word changed under stall")
  `PCW_ASSERT(a_rdy_empty, !out_valid |-> in_ready, "input stalled with empty output")
  `PCW_ASSERT(a_rdy_taken, out_ready |-> in_ready, "input stalled while output drains")
  `PCW_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
endmodule

bind polynomial_coordinate_warp pcw_checker u_pcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .x_out     (out_word.x_out),
  .y_out     (out_word.y_out)
);
